/* rtl/core/entity_slot_registry_assert.svh */
// Assertion macros used by the entity slot registry request sequencer.
`ifndef ENTITY_SLOT_REGISTRY_ASSERT_SVH
`define ENTITY_SLOT_REGISTRY_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ESR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("entity slot registry: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ESR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("entity slot registry: next-cycle check failed");

`endif

/* rtl/core/esr_pkg.sv */
// Shared constants, codes and types of the entity slot registry.
package esr_pkg;

    localparam int SLOTS          = 256;
    localparam int SLOT_W         = $clog2(SLOTS);
    localparam int CNT_W          = SLOT_W + 1;
    localparam int CLIENT_BASE    = 4096;
    localparam int NET_CAP        = (SLOTS < CLIENT_BASE) ? SLOTS : CLIENT_BASE;
    localparam int COMPONENT_BITS = 32;
    localparam int MASK_W         = COMPONENT_BITS;
    localparam int ID_W           = 64;
    localparam int ENTRY_W        = ID_W + 3 * MASK_W;

    localparam logic [ID_W-1:0] INVALID_ID = {32'hFFFF_FFFF, 32'h0};

    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_PLACE   = 3'd1;
    localparam logic [2:0] REQ_DESTROY = 3'd2;
    localparam logic [2:0] REQ_ASSIGN  = 3'd3;
    localparam logic [2:0] REQ_REMOVE  = 3'd4;
    localparam logic [2:0] REQ_CLEAN   = 3'd5;
    localparam logic [2:0] REQ_DIRTY   = 3'd6;
    localparam logic [2:0] REQ_QUERY   = 3'd7;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic latch;
        logic look;
        logic exec;
    } t_cmd;

endpackage

/* rtl/core/esr_ctrl.sv */
// Request sequencer of the entity slot registry: handshakes and command issue.
module esr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output esr_pkg::t_cmd o_cmd
);
    import esr_pkg::*;
    `include "entity_slot_registry_assert.svh"

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    w_cmd.latch = 1'b1;
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: begin
                w_cmd.look = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                // The result register may only be reloaded once the last result is gone.
                if (!(r_out_valid && i_out_stall)) begin
                    w_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd       = w_cmd;
    assign o_out_valid = r_out_valid;

    `ESR_ASSERT_NOW(a_exec_out_free, i_clk, i_rst_n, w_cmd.exec, !(r_out_valid && i_out_stall))
    `ESR_ASSERT_NEXT(a_accept_look, i_clk, i_rst_n, (r_state == S_IDLE) && i_in_valid, r_state == S_LOOK)
    `ESR_ASSERT_NEXT(a_exec_valid, i_clk, i_rst_n, w_cmd.exec, r_out_valid && (r_state == S_IDLE))

endmodule

/* rtl/core/esr_dpath.sv */
// Datapath of the entity slot registry: slot tables, free stacks, counts and results.
module esr_dpath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  esr_pkg::t_cmd           i_cmd,
    input  logic [2:0]              i_req_type,
    input  logic [esr_pkg::ID_W-1:0] i_entity_id,
    input  logic [4:0]              i_component,
    input  logic                    i_send_updates,
    input  logic                    i_client_side,
    output logic [esr_pkg::ID_W-1:0] o_result_id,
    output logic                    o_present,
    output logic                    o_dirty,
    output logic                    o_sending_updates,
    output logic [31:0]             o_data_slot,
    output logic [1:0]              o_status
);
    import esr_pkg::*;

    // Slot entries: {id, presence, dirty, update}.
    logic [ENTRY_W-1:0] r_net_mem [SLOTS];
    logic [ENTRY_W-1:0] r_cli_mem [SLOTS];
    logic [SLOTS-1:0]   r_net_vld, r_cli_vld;
    logic [SLOT_W-1:0]  r_net_stk [SLOTS];
    logic [SLOT_W-1:0]  r_cli_stk [SLOTS];

    logic [CNT_W-1:0]   r_net_used, r_cli_used, r_net_free, r_cli_free;

    logic [2:0]         r_req;
    logic [ID_W-1:0]    r_id;
    logic [4:0]         r_comp;
    logic               r_send, r_cside;

    logic [SLOT_W-1:0]  r_net_stk_rd, r_cli_stk_rd;
    logic [ENTRY_W-1:0] r_ent;
    logic               r_vld_rd, r_tbl, r_lt_used, r_lt_cap, r_have_free, r_can_append;
    logic [SLOT_W-1:0]  r_slot;

    logic [ID_W-1:0]    r_out_id;
    logic               r_present, r_dirty, r_upd;
    logic [1:0]         r_status;

    // Lookup stage signals.
    logic [31:0]        w_upper, w_idx;
    logic               w_is_cli, w_tbl, w_have_free;
    logic [CNT_W-1:0]   w_used_sel, w_free_sel;
    logic [32:0]        w_cap_sel;
    logic [SLOT_W-1:0]  w_slot;

    // Execute stage signals.
    logic [ENTRY_W-1:0] w_ent;
    logic [ID_W-1:0]    w_id_old, n_id, n_out_id;
    logic [MASK_W-1:0]  w_pres, w_dirt, w_upd, n_pres, n_dirt, n_upd, w_bit;
    logic               w_comp_ok, w_rep, w_wr, w_dec_free, w_push, w_inc_used, w_set_used;
    logic [1:0]         n_status;
    logic [31:0]        w_base;
    logic [CNT_W-1:0]   w_x_free;
    logic               w_p;

    // Request latch and free-stack top reads at the accept edge.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req   <= i_req_type;
            r_id    <= i_entity_id;
            r_comp  <= i_component;
            r_send  <= i_send_updates;
            r_cside <= i_client_side;
        end
        r_net_stk_rd <= r_net_stk[SLOT_W'(r_net_free - CNT_W'(1))];
        r_cli_stk_rd <= r_cli_stk[SLOT_W'(r_cli_free - CNT_W'(1))];
    end

    always_comb begin
        w_upper     = r_id[63:32];
        w_is_cli    = w_upper >= 32'(CLIENT_BASE);
        w_idx       = w_is_cli ? (w_upper - 32'(CLIENT_BASE)) : w_upper;
        w_tbl       = (r_req == REQ_ALLOC) ? r_cside : w_is_cli;
        w_used_sel  = w_tbl ? r_cli_used : r_net_used;
        w_free_sel  = w_tbl ? r_cli_free : r_net_free;
        w_cap_sel   = w_tbl ? 33'(SLOTS) : 33'(NET_CAP);
        w_have_free = w_free_sel != '0;
        if (r_req == REQ_ALLOC) begin
            w_slot = w_have_free ? (r_cside ? r_cli_stk_rd : r_net_stk_rd)
                                 : w_used_sel[SLOT_W-1:0];
        end else begin
            w_slot = w_idx[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_tbl        <= w_tbl;
            r_slot       <= w_slot;
            r_lt_used    <= {1'b0, w_idx} < 33'(w_used_sel);
            r_lt_cap     <= {1'b0, w_idx} < w_cap_sel;
            r_have_free  <= w_have_free;
            r_can_append <= 33'(w_used_sel) < w_cap_sel;
            r_ent        <= w_tbl ? r_cli_mem[w_slot] : r_net_mem[w_slot];
            r_vld_rd     <= w_tbl ? r_cli_vld[w_slot] : r_net_vld[w_slot];
        end
    end

    always_comb begin
        w_ent      = r_vld_rd ? r_ent : {INVALID_ID, {(3 * MASK_W){1'b0}}};
        w_id_old   = w_ent[ENTRY_W-1 -: ID_W];
        w_pres     = w_ent[3*MASK_W-1 -: MASK_W];
        w_dirt     = w_ent[2*MASK_W-1 -: MASK_W];
        w_upd      = w_ent[MASK_W-1:0];
        w_comp_ok  = 32'(r_comp) < 32'(COMPONENT_BITS);
        w_bit      = w_comp_ok ? (MASK_W'(1) << r_comp) : '0;
        w_base     = r_tbl ? 32'(CLIENT_BASE) : 32'd0;
        w_x_free   = r_tbl ? r_cli_free : r_net_free;
        n_id       = w_id_old;
        n_pres     = w_pres;
        n_dirt     = w_dirt;
        n_upd      = w_upd;
        n_out_id   = r_id;
        n_status   = ST_DONE;
        w_rep      = 1'b1;
        w_wr       = 1'b0;
        w_dec_free = 1'b0;
        w_push     = 1'b0;
        w_inc_used = 1'b0;
        w_set_used = 1'b0;
        case (r_req)
            REQ_ALLOC: begin
                if (r_have_free) begin
                    n_id       = {32'(r_slot) + w_base, w_id_old[31:0]};
                    w_wr       = 1'b1;
                    w_dec_free = 1'b1;
                    n_out_id   = n_id;
                end else if (r_can_append) begin
                    n_id       = {32'(r_slot) + w_base, 32'd0};
                    w_wr       = 1'b1;
                    w_inc_used = 1'b1;
                    n_out_id   = n_id;
                end else begin
                    n_out_id = INVALID_ID;
                    n_status = ST_NO_SLOT;
                    w_rep    = 1'b0;
                end
            end
            REQ_PLACE: begin
                if (!r_lt_cap) begin
                    n_status = ST_NO_SLOT;
                    w_rep    = 1'b0;
                end else begin
                    n_id       = r_id;
                    w_wr       = 1'b1;
                    w_set_used = !r_lt_used;
                end
            end
            default: begin
                if (!r_lt_used) begin
                    n_status = ST_IGNORED;
                    w_rep    = 1'b0;
                end else if (r_req == REQ_DESTROY) begin
                    if (32'(w_x_free) >= 32'(SLOTS)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_id   = {32'hFFFF_FFFF, r_id[31:0] + 32'd1};
                        n_pres = '0;
                        n_dirt = '0;
                        n_upd  = '0;
                        w_wr   = 1'b1;
                        w_push = 1'b1;
                    end
                end else if (r_req == REQ_QUERY) begin
                    n_status = ST_DONE;
                end else if (!w_comp_ok) begin
                    n_status = ST_IGNORED;
                end else if (r_req == REQ_ASSIGN) begin
                    n_pres = w_pres | w_bit;
                    if (r_send) begin
                        n_upd = w_upd | w_bit;
                    end
                    w_wr = 1'b1;
                end else if (r_req == REQ_REMOVE) begin
                    if (w_id_old != r_id) begin
                        n_status = ST_IGNORED;
                    end else begin
                        n_pres = w_pres & ~w_bit;
                        w_wr   = 1'b1;
                    end
                end else if ((w_pres & w_bit) == '0) begin
                    n_status = ST_IGNORED;
                end else if (r_req == REQ_CLEAN) begin
                    n_dirt = w_dirt & ~w_bit;
                    w_wr   = 1'b1;
                end else begin
                    n_dirt = w_dirt | w_bit;
                    w_wr   = 1'b1;
                end
            end
        endcase
        w_p = w_rep && ((n_pres & w_bit) != '0);
    end

    // Slot table write-back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr) begin
            if (r_tbl) begin
                r_cli_mem[r_slot] <= {n_id, n_pres, n_dirt, n_upd};
            end else begin
                r_net_mem[r_slot] <= {n_id, n_pres, n_dirt, n_upd};
            end
        end
        if (i_cmd.exec && w_push) begin
            if (r_tbl) begin
                r_cli_stk[w_x_free[SLOT_W-1:0]] <= r_slot;
            end else begin
                r_net_stk[w_x_free[SLOT_W-1:0]] <= r_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_vld  <= '0;
            r_cli_vld  <= '0;
            r_net_used <= '0;
            r_cli_used <= '0;
            r_net_free <= '0;
            r_cli_free <= '0;
        end else if (i_cmd.exec) begin
            if (w_wr) begin
                if (r_tbl) begin
                    r_cli_vld[r_slot] <= 1'b1;
                end else begin
                    r_net_vld[r_slot] <= 1'b1;
                end
            end
            if (r_tbl) begin
                if (w_inc_used) r_cli_used <= r_cli_used + CNT_W'(1);
                if (w_set_used) r_cli_used <= CNT_W'(r_slot) + CNT_W'(1);
                if (w_dec_free) r_cli_free <= r_cli_free - CNT_W'(1);
                if (w_push)     r_cli_free <= r_cli_free + CNT_W'(1);
            end else begin
                if (w_inc_used) r_net_used <= r_net_used + CNT_W'(1);
                if (w_set_used) r_net_used <= CNT_W'(r_slot) + CNT_W'(1);
                if (w_dec_free) r_net_free <= r_net_free - CNT_W'(1);
                if (w_push)     r_net_free <= r_net_free + CNT_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_id  <= n_out_id;
            r_present <= w_p;
            r_dirty   <= w_p && ((n_dirt & w_bit) != '0);
            r_upd     <= w_p && ((n_upd & w_bit) != '0);
            r_status  <= n_status;
        end
    end

    assign o_result_id       = r_out_id;
    assign o_data_slot       = r_out_id[63:32];
    assign o_present         = r_present;
    assign o_dirty           = r_dirty;
    assign o_sending_updates = r_upd;
    assign o_status          = r_status;

endmodule

/* rtl/core/entity_slot_registry.sv */
// Top level of the entity slot registry.
// Generational-index slot allocator with a networked and a client-side slot table, each
// with a LIFO free-index stack. From acceptance to result, a request is first captured
// (and both free-stack tops are read), then its addressed slot is looked up in its table
// memory, and last the slot, stack and counts are updated and the result register is
// loaded. A new request is accepted only after the previous one has loaded its result;
// a result left waiting holds back the execute step of the next request.
// Slot valid bits are cleared at reset, so no clearing pass is needed.
module entity_slot_registry (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [2:0]               i_req_type,
    input  logic [esr_pkg::ID_W-1:0] i_entity_id,
    input  logic [4:0]               i_component,
    input  logic                     i_send_updates,
    input  logic                     i_client_side,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [esr_pkg::ID_W-1:0] o_result_id,
    output logic                     o_present,
    output logic                     o_dirty,
    output logic                     o_sending_updates,
    output logic [31:0]              o_data_slot,
    output logic [1:0]               o_status
);
    import esr_pkg::*;

    t_cmd w_cmd;

    esr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    esr_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_req_type        (i_req_type),
        .i_entity_id       (i_entity_id),
        .i_component       (i_component),
        .i_send_updates    (i_send_updates),
        .i_client_side     (i_client_side),
        .o_result_id       (o_result_id),
        .o_present         (o_present),
        .o_dirty           (o_dirty),
        .o_sending_updates (o_sending_updates),
        .o_data_slot       (o_data_slot),
        .o_status          (o_status)
    );

endmodule
